// File: design/sbfr_pkg.sv
// Shared types and constants for the single-bus sensor frame receiver.
// No dependencies; every other design file except sbfr_tick_if refers to this package by scope.
`default_nettype none

package sbfr_pkg;

	localparam int unsigned REG_W       = 16;
	localparam int unsigned APB_ADDR_W  = 5;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned FRAME_BITS  = 40;
	localparam int unsigned BIT_IDX_W   = 6;
	localparam int unsigned HUM_W       = 16;
	localparam int unsigned TEMP_W      = 15;
	localparam int unsigned STATUS_W    = 3;

	localparam logic [REG_W-1:0] RELEASE_TICKS_RST  = 16'd1000;
	localparam logic [REG_W-1:0] HOST_LOW_TICKS_RST = 16'd1000;
	localparam logic [REG_W-1:0] SETTLE_TICKS_RST   = 16'd40;
	localparam logic [REG_W-1:0] ACK_LOW_LIMIT_RST  = 16'd80;
	localparam logic [REG_W-1:0] ACK_HIGH_LIMIT_RST = 16'd160;
	localparam logic [REG_W-1:0] ONE_THRESHOLD_RST  = 16'd50;
	localparam logic [REG_W-1:0] BIT_TIMEOUT_RST    = 16'd1000;

	typedef enum logic [2:0] {
		REG_RELEASE_TICKS  = 3'd0,
		REG_HOST_LOW_TICKS = 3'd1,
		REG_SETTLE_TICKS   = 3'd2,
		REG_ACK_LOW_LIMIT  = 3'd3,
		REG_ACK_HIGH_LIMIT = 3'd4,
		REG_ONE_THRESHOLD  = 3'd5,
		REG_BIT_TIMEOUT    = 3'd6
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE    = 3'd0,
		ST_OK      = 3'd1,
		ST_NOACK   = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_CKSUM   = 3'd4
	} status_t;

	typedef struct packed {
		logic [REG_W-1:0] release_ticks;
		logic [REG_W-1:0] host_low_ticks;
		logic [REG_W-1:0] settle_ticks;
		logic [REG_W-1:0] ack_low_limit;
		logic [REG_W-1:0] ack_high_limit;
		logic [REG_W-1:0] one_threshold;
		logic [REG_W-1:0] bit_timeout;
	} cfg_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		status_t           status;
		logic [HUM_W-1:0]  humidity;
		logic [TEMP_W-1:0] temperature;
		logic              negative;
	} result_t;

endpackage

`default_nettype wire

// File: design/sbfr_tick_if.sv
// Input channel: one tick transaction with start request and sampled line level.
// No dependencies.
`default_nettype none

interface sbfr_tick_if;
	logic valid;
	logic ready;
	logic start_req;
	logic line_level;

	modport source(output valid, output start_req, output line_level, input ready);
	modport sink(input valid, input start_req, input line_level, output ready);
endinterface

`default_nettype wire

// File: design/sbfr_result_if.sv
// Result channel: one transaction per tick with line drive, status and stored reading.
// Field widths come from sbfr_pkg.
`default_nettype none

interface sbfr_result_if;
	logic                          valid;
	logic                          ready;
	logic                          drive_low;
	logic                          busy_res;
	logic                          done_res;
	logic [sbfr_pkg::STATUS_W-1:0] status;
	logic [sbfr_pkg::HUM_W-1:0]    humidity;
	logic [sbfr_pkg::TEMP_W-1:0]   temperature;
	logic                          negative;

	modport source(output valid, output drive_low, output busy_res, output done_res,
		output status, output humidity, output temperature, output negative, input ready);
	modport sink(input valid, input drive_low, input busy_res, input done_res,
		input status, input humidity, input temperature, input negative, output ready);
endinterface

`default_nettype wire

// File: design/single_bus_sensor_frame_receiver_core.sv
// Single-bus humidity/temperature sensor frame receiver, top level.
// Uses sbfr_pkg, sbfr_tick_if, sbfr_result_if, sbfr_apb_regs and sbfr_engine.
//
//   channel  | kind        | carries
//   ---------+-------------+------------------------------------------------
//   tick     | valid/ready | start_req, line_level (one microsecond tick)
//   result   | valid/ready | drive_low, busy_res, done_res, status, reading
//   apb      | APB write   | seven 16-bit timing registers at 4*index
//
// One tick transaction per clock unless result stalls; a tick passes the input
// register, then the result register. The protocol state updates once per tick
// as it moves from the input register into the result register. Result stalls
// hold both registers; tick.ready drops only when both are full. Reset clears
// control state and loads register defaults; no clearing pass.
`default_nettype none

module single_bus_sensor_frame_receiver_core #(
	parameter int unsigned TICK_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	sbfr_tick_if.sink                            tick,
	sbfr_result_if.source                        result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [sbfr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [sbfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [sbfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	sbfr_pkg::cfg_t    cfg;
	sbfr_pkg::result_t res_d;
	sbfr_pkg::result_t res_s2;
	logic              valid_s1, valid_s2;
	logic              start_s1, line_s1;
	logic              adv;
	logic              take;

	sbfr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbfr_engine #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.start_req  (start_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res_d)
	);

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || adv;
	assign take       = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_s1 <= tick.start_req;
			line_s1  <= tick.line_level;
		end
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid       = valid_s2;
	assign result.drive_low   = res_s2.drive_low;
	assign result.busy_res    = res_s2.busy_res;
	assign result.done_res    = res_s2.done_res;
	assign result.status      = res_s2.status;
	assign result.humidity    = res_s2.humidity;
	assign result.temperature = res_s2.temperature;
	assign result.negative    = res_s2.negative;

`ifndef SYNTH
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.done_res && result.busy_res))
		else $error("done and busy on the same transaction");

	a_status_iff_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.status != sbfr_pkg::ST_NONE) == result.done_res))
		else $error("status does not match done");

	a_drive_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.drive_low) |-> result.busy_res)
		else $error("line driven low while not busy");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("tick channel stalled with room to accept");
`endif

endmodule

`default_nettype wire

// File: design/sbfr_apb_regs.sv
// APB configuration registers of the frame receiver (timing limits).
// Depends on sbfr_pkg for the register map, reset values and cfg_t.
`default_nettype none

module sbfr_apb_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [sbfr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [sbfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [sbfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output sbfr_pkg::cfg_t                       cfg
);

	sbfr_pkg::cfg_t     cfg_q;
	sbfr_pkg::reg_idx_t idx;
	logic               wr_en;
	logic [sbfr_pkg::REG_W-1:0] wdata;
	logic [sbfr_pkg::REG_W-1:0] rdata;

	assign idx    = sbfr_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign wdata  = pwdata[sbfr_pkg::REG_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.release_ticks  <= sbfr_pkg::RELEASE_TICKS_RST;
			cfg_q.host_low_ticks <= sbfr_pkg::HOST_LOW_TICKS_RST;
			cfg_q.settle_ticks   <= sbfr_pkg::SETTLE_TICKS_RST;
			cfg_q.ack_low_limit  <= sbfr_pkg::ACK_LOW_LIMIT_RST;
			cfg_q.ack_high_limit <= sbfr_pkg::ACK_HIGH_LIMIT_RST;
			cfg_q.one_threshold  <= sbfr_pkg::ONE_THRESHOLD_RST;
			cfg_q.bit_timeout    <= sbfr_pkg::BIT_TIMEOUT_RST;
		end else if (wr_en) begin
			case (idx)
				sbfr_pkg::REG_RELEASE_TICKS:  cfg_q.release_ticks  <= wdata;
				sbfr_pkg::REG_HOST_LOW_TICKS: cfg_q.host_low_ticks <= wdata;
				sbfr_pkg::REG_SETTLE_TICKS:   cfg_q.settle_ticks   <= wdata;
				sbfr_pkg::REG_ACK_LOW_LIMIT:  cfg_q.ack_low_limit  <= wdata;
				sbfr_pkg::REG_ACK_HIGH_LIMIT: cfg_q.ack_high_limit <= wdata;
				sbfr_pkg::REG_ONE_THRESHOLD:  cfg_q.one_threshold  <= wdata;
				sbfr_pkg::REG_BIT_TIMEOUT:    cfg_q.bit_timeout    <= wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sbfr_pkg::REG_RELEASE_TICKS:  rdata = cfg_q.release_ticks;
			sbfr_pkg::REG_HOST_LOW_TICKS: rdata = cfg_q.host_low_ticks;
			sbfr_pkg::REG_SETTLE_TICKS:   rdata = cfg_q.settle_ticks;
			sbfr_pkg::REG_ACK_LOW_LIMIT:  rdata = cfg_q.ack_low_limit;
			sbfr_pkg::REG_ACK_HIGH_LIMIT: rdata = cfg_q.ack_high_limit;
			sbfr_pkg::REG_ONE_THRESHOLD:  rdata = cfg_q.one_threshold;
			sbfr_pkg::REG_BIT_TIMEOUT:    rdata = cfg_q.bit_timeout;
			default:                      rdata = '0;
		endcase
	end

	assign prdata = {{(sbfr_pkg::APB_DATA_W - sbfr_pkg::REG_W){1'b0}}, rdata};

endmodule

`default_nettype wire

// File: design/sbfr_engine.sv
// Protocol state machine: start pulse, acknowledge, bit timing, checksum.
// Computes one tick's result from state and inputs; state advances on step.
// Depends on sbfr_pkg.
`default_nettype none

module sbfr_engine #(
	parameter int unsigned TICK_WIDTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic           start_req,
	input  wire logic           line_level,
	input  sbfr_pkg::cfg_t      cfg,
	output sbfr_pkg::result_t   res
);

	localparam int unsigned CMP_W = (TICK_WIDTH > sbfr_pkg::REG_W) ? TICK_WIDTH : sbfr_pkg::REG_W;
	localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_RELEASE = 4'd1,
		PH_HOSTLOW = 4'd2,
		PH_SETTLE  = 4'd3,
		PH_ACKLOW  = 4'd4,
		PH_ACKHIGH = 4'd5,
		PH_ACKEND  = 4'd6,
		PH_BITLOW  = 4'd7,
		PH_BITHIGH = 4'd8
	} phase_t;

	phase_t                                 ph_q, ph_d;
	logic [TICK_WIDTH-1:0]                  tc_q, tc_d, tinc;
	logic [sbfr_pkg::BIT_IDX_W-1:0]         bi_q, bi_d;
	logic [sbfr_pkg::FRAME_BITS-1:0]        rb_q, rb_d;
	logic [sbfr_pkg::HUM_W-1:0]             hum_q, hum_d;
	logic [sbfr_pkg::TEMP_W-1:0]            temp_q, temp_d;
	logic                                   neg_q, neg_d;
	logic                                   tsat;
	logic                                   done;
	sbfr_pkg::status_t                      st;
	logic                                   bit_one;
	logic [sbfr_pkg::FRAME_BITS-1:0]        rb_sh;
	logic [7:0]                             cks_sum;

	function automatic logic at_least(logic [TICK_WIDTH-1:0] t, logic [sbfr_pkg::REG_W-1:0] lim);
		return (CMP_W'(t) >= CMP_W'(lim)) || (t == TICK_MAX);
	endfunction

	function automatic logic above(logic [TICK_WIDTH-1:0] t, logic [sbfr_pkg::REG_W-1:0] lim);
		return (CMP_W'(t) > CMP_W'(lim)) || (t == TICK_MAX);
	endfunction

	assign tsat    = (tc_q == TICK_MAX);
	assign tinc    = tsat ? tc_q : tc_q + TICK_WIDTH'(1);
	assign bit_one = (CMP_W'(tc_q) > CMP_W'(cfg.one_threshold));
	assign rb_sh   = {rb_q[sbfr_pkg::FRAME_BITS-2:0], bit_one};
	assign cks_sum = rb_sh[39:32] + rb_sh[31:24] + rb_sh[23:16] + rb_sh[15:8];

	always_comb begin
		ph_d   = ph_q;
		tc_d   = tc_q;
		bi_d   = bi_q;
		rb_d   = rb_q;
		hum_d  = hum_q;
		temp_d = temp_q;
		neg_d  = neg_q;
		done   = 1'b0;
		st     = sbfr_pkg::ST_NONE;
		case (ph_q)
			PH_IDLE: begin
				if (start_req) begin
					ph_d = PH_RELEASE;
					tc_d = '0;
					bi_d = '0;
					rb_d = '0;
				end
			end
			PH_RELEASE: begin
				tc_d = tinc;
				if (at_least(tinc, cfg.release_ticks)) begin
					ph_d = PH_HOSTLOW;
					tc_d = '0;
				end
			end
			PH_HOSTLOW: begin
				tc_d = tinc;
				if (at_least(tinc, cfg.host_low_ticks)) begin
					ph_d = PH_SETTLE;
					tc_d = '0;
				end
			end
			PH_SETTLE: begin
				tc_d = tinc;
				if (at_least(tinc, cfg.settle_ticks)) begin
					ph_d = PH_ACKLOW;
					tc_d = '0;
				end
			end
			PH_ACKLOW: begin
				if (!line_level) begin
					ph_d = PH_ACKHIGH;
					tc_d = '0;
				end else begin
					tc_d = tinc;
					if (above(tinc, cfg.ack_low_limit)) begin
						done = 1'b1;
						st   = sbfr_pkg::ST_NOACK;
					end
				end
			end
			PH_ACKHIGH: begin
				if (line_level) begin
					ph_d = PH_ACKEND;
					tc_d = '0;
				end else begin
					tc_d = tinc;
					if (above(tinc, cfg.ack_high_limit)) begin
						done = 1'b1;
						st   = sbfr_pkg::ST_NOACK;
					end
				end
			end
			PH_ACKEND: begin
				if (!line_level) begin
					ph_d = PH_BITLOW;
					tc_d = '0;
				end
			end
			PH_BITLOW: begin
				if (line_level) begin
					ph_d = PH_BITHIGH;
					tc_d = '0;
				end
			end
			PH_BITHIGH: begin
				if (!line_level) begin
					rb_d = rb_sh;
					bi_d = bi_q + sbfr_pkg::BIT_IDX_W'(1);
					if (bi_d >= sbfr_pkg::BIT_IDX_W'(sbfr_pkg::FRAME_BITS)) begin
						done = 1'b1;
						if (cks_sum == rb_sh[7:0]) begin
							st     = sbfr_pkg::ST_OK;
							hum_d  = rb_sh[39:24];
							temp_d = rb_sh[22:8];
							neg_d  = rb_sh[23];
						end else begin
							st     = sbfr_pkg::ST_CKSUM;
							hum_d  = '0;
							temp_d = '0;
							neg_d  = 1'b0;
						end
					end else begin
						ph_d = PH_BITLOW;
						tc_d = '0;
					end
				end else begin
					tc_d = tinc;
					if (at_least(tinc, cfg.bit_timeout)) begin
						done = 1'b1;
						st   = sbfr_pkg::ST_TIMEOUT;
					end
				end
			end
			default: begin
				ph_d = PH_IDLE;
				tc_d = '0;
			end
		endcase
		if (done) begin
			ph_d = PH_IDLE;
			tc_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			tc_q   <= '0;
			bi_q   <= '0;
			rb_q   <= '0;
			hum_q  <= '0;
			temp_q <= '0;
			neg_q  <= 1'b0;
		end else if (step) begin
			ph_q   <= ph_d;
			tc_q   <= tc_d;
			bi_q   <= bi_d;
			rb_q   <= rb_d;
			hum_q  <= hum_d;
			temp_q <= temp_d;
			neg_q  <= neg_d;
		end
	end

	always_comb begin
		res.drive_low   = (ph_d == PH_HOSTLOW);
		res.busy_res    = (ph_d != PH_IDLE);
		res.done_res    = done;
		res.status      = st;
		res.humidity    = hum_d;
		res.temperature = temp_d;
		res.negative    = neg_d;
	end

endmodule

`default_nettype wire
